// File: rtl/core/sfr_pkg.sv
// Package for the streaming find-and-replace block: payload structs,
// controller/datapath command and status types, register indexes.
// No dependencies.
`default_nettype none

package sfr_pkg;

    localparam int SFR_MAX_PATTERN = 8;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_PATTERN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LENGTH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_PATTERN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LENGTH  = CFG_IDX_W'(3);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } sfr_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic [31:0] replacements;
    } sfr_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DROP,
        ST_FLUSH,
        ST_REPL,
        ST_MARK
    } sfr_state_t;

    typedef enum logic [1:0] {
        OSEL_OLDEST,
        OSEL_REPL,
        OSEL_MARK
    } sfr_osel_t;

    typedef struct packed {
        logic      in_ready;
        logic      match;
        logic      shift;
        logic      emit;
        sfr_osel_t osel;
        logic      last;
        logic      rep_inc;
        logic      total_clr;
    } sfr_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic prefix;
        logic full;
        logic count_zero;
        logic count_one;
        logic repl_zero;
        logic repl_last;
        logic eos;
        logic emitted;
        logic out_free;
    } sfr_status_t;

endpackage

`default_nettype wire

// File: rtl/core/sfr_stream_if.sv
// Valid/ready stream channel with a typed payload.
// No dependencies.
`default_nettype none

interface sfr_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sfr_cfg_if.sv
// Register write channel: valid/ready with register index and write data.
// Depends on sfr_pkg.
`default_nettype none

interface sfr_cfg_if import sfr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sfr_ctrl.sv
// Controller for the find-and-replace block: sequences accept, prefix check,
// drops, replacement output, flush and end marker. Depends on sfr_pkg.
`default_nettype none

module sfr_ctrl import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sfr_status_t status,
    output sfr_cmd_t    cmd
);

    sfr_state_t state_reg;
    sfr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!status.prefix)
                    state_next = ST_DROP;
                else if (status.full)
                begin
                    if (!status.repl_zero)
                        state_next = ST_REPL;
                    else if (status.eos)
                        state_next = ST_MARK;
                    else
                        state_next = ST_IDLE;
                end
                else if (status.eos)
                begin
                    if (!status.count_zero)
                        state_next = ST_FLUSH;
                    else if (!status.emitted)
                        state_next = ST_MARK;
                    else
                        state_next = ST_IDLE;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DROP:
            begin
                if (status.out_free)
                    state_next = ST_CHECK;
            end
            ST_FLUSH:
            begin
                if (status.out_free && status.count_one)
                    state_next = ST_IDLE;
            end
            ST_REPL:
            begin
                if (status.out_free && status.repl_last)
                    state_next = ST_IDLE;
            end
            ST_MARK:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.osel = OSEL_OLDEST;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.match = status.prefix && status.full;
                // stream ended on a dropped byte: nothing left to send
                cmd.total_clr = status.prefix && !status.full && status.eos
                                && status.count_zero && status.emitted;
            end
            ST_DROP:
            begin
                cmd.emit  = status.out_free;
                cmd.shift = status.out_free;
                cmd.osel  = OSEL_OLDEST;
                // after a drop no match is possible, so a lone byte is final
                cmd.last  = status.eos && status.count_one;
            end
            ST_FLUSH:
            begin
                cmd.emit      = status.out_free;
                cmd.shift     = status.out_free;
                cmd.osel      = OSEL_OLDEST;
                cmd.last      = status.count_one;
                cmd.total_clr = status.out_free && status.count_one;
            end
            ST_REPL:
            begin
                cmd.emit      = status.out_free;
                cmd.rep_inc   = status.out_free;
                cmd.osel      = OSEL_REPL;
                cmd.last      = status.eos && status.repl_last;
                cmd.total_clr = status.out_free && status.eos && status.repl_last;
            end
            ST_MARK:
            begin
                cmd.emit      = status.out_free;
                cmd.osel      = OSEL_MARK;
                cmd.last      = 1'b1;
                cmd.total_clr = status.out_free;
            end
            default:
            begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/sfr_datapath.sv
// Datapath: config registers, pending byte buffer, latched search pattern,
// prefix compare, match counter and output register. Depends on sfr_pkg
// and the stream/config interfaces.
`default_nettype none

module sfr_datapath import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = SFR_MAX_PATTERN
)
(
    input  logic         clk,
    input  logic         rst_n,
    sfr_cfg_if.sink      cfg,
    sfr_stream_if.sink   din,
    sfr_stream_if.source dout,
    input  sfr_cmd_t     cmd,
    output sfr_status_t  status
);

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PW = 8 * MAX_PATTERN;

    logic [63:0]   search_pattern_reg;
    logic [3:0]    search_length_reg;
    logic [63:0]   replace_pattern_reg;
    logic [3:0]    replace_length_reg;

    logic [PW-1:0] act_pat_reg;
    logic [CW-1:0] act_len_reg;
    logic [7:0]    pend_reg [MAX_PATTERN];
    logic [CW-1:0] count_reg;
    logic [IW-1:0] rep_idx_reg;
    logic [31:0]   total_reg;
    logic          eos_reg;
    logic          emitted_reg;
    logic          out_valid_reg;
    sfr_out_t      out_data_reg;

    logic          accept;
    logic          out_free;
    logic          prefix;
    logic [CW-1:0] slen_clamp;
    logic [CW-1:0] rlen_clamp;
    logic [7:0]    repl_byte;
    logic [7:0]    sel_byte;

    assign cfg.ready = 1'b1;
    assign din.ready = cmd.in_ready;
    assign accept    = din.valid && cmd.in_ready;
    assign out_free  = !out_valid_reg || dout.ready;

    assign dout.valid = out_valid_reg;
    assign dout.data  = out_data_reg;

    always_comb
    begin
        if (search_length_reg == 4'd0)
            slen_clamp = CW'(1);
        else if (search_length_reg > 4'(MAX_PATTERN))
            slen_clamp = CW'(MAX_PATTERN);
        else
            slen_clamp = CW'(search_length_reg);

        if (replace_length_reg > 4'(MAX_PATTERN))
            rlen_clamp = CW'(MAX_PATTERN);
        else
            rlen_clamp = CW'(replace_length_reg);
    end

    // bytes at or past the fill level are don't-care
    always_comb
    begin
        prefix = (count_reg <= act_len_reg);
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (CW'(i) < count_reg && pend_reg[i] != act_pat_reg[8*i +: 8])
                prefix = 1'b0;
        end
    end

    assign repl_byte = replace_pattern_reg[{rep_idx_reg, 3'b000} +: 8];

    always_comb
    begin
        unique case (cmd.osel)
            OSEL_OLDEST: sel_byte = pend_reg[0];
            OSEL_REPL:   sel_byte = repl_byte;
            OSEL_MARK:   sel_byte = 8'd0;
            default:     sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        status            = '0;
        status.in_valid   = din.valid;
        status.prefix     = prefix;
        status.full       = (count_reg == act_len_reg);
        status.count_zero = (count_reg == '0);
        status.count_one  = (count_reg == CW'(1));
        status.repl_zero  = (rlen_clamp == '0);
        status.repl_last  = (CW'(rep_idx_reg) == rlen_clamp - CW'(1));
        status.eos        = eos_reg;
        status.emitted    = emitted_reg;
        status.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_pattern_reg  <= '0;
            search_length_reg   <= 4'd1;
            replace_pattern_reg <= '0;
            replace_length_reg  <= 4'd0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SEARCH_PATTERN:  search_pattern_reg  <= cfg.data;
                CFG_SEARCH_LENGTH:   search_length_reg   <= cfg.data[3:0];
                CFG_REPLACE_PATTERN: replace_pattern_reg <= cfg.data;
                CFG_REPLACE_LENGTH:  replace_length_reg  <= cfg.data[3:0];
                default:             search_length_reg   <= search_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_pat_reg   <= '0;
            act_len_reg   <= CW'(1);
            count_reg     <= '0;
            rep_idx_reg   <= '0;
            total_reg     <= '0;
            eos_reg       <= 1'b0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                // new search pattern takes effect only between partial matches
                if (count_reg == '0)
                begin
                    act_pat_reg <= search_pattern_reg[PW-1:0];
                    act_len_reg <= slen_clamp;
                end
                count_reg   <= count_reg + CW'(1);
                eos_reg     <= din.data.end_of_stream;
                emitted_reg <= 1'b0;
            end
            else if (cmd.match)
                count_reg <= '0;
            else if (cmd.shift)
                count_reg <= count_reg - CW'(1);

            if (cmd.match)
                rep_idx_reg <= '0;
            else if (cmd.rep_inc)
                rep_idx_reg <= rep_idx_reg + IW'(1);

            if (cmd.total_clr)
                total_reg <= '0;
            else if (cmd.match && total_reg != '1)
                total_reg <= total_reg + 32'd1;

            if (cmd.emit)
            begin
                emitted_reg   <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg[count_reg[IW-1:0]] <= din.data.in_byte;
        else if (cmd.shift)
        begin
            for (int i = 0; i < MAX_PATTERN - 1; i++)
                pend_reg[i] <= pend_reg[i+1];
        end

        if (cmd.emit)
        begin
            out_data_reg.out_byte     <= sel_byte;
            out_data_reg.byte_valid   <= (cmd.osel != OSEL_MARK);
            out_data_reg.last         <= cmd.last;
            out_data_reg.replacements <= total_reg;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= act_len_reg)
        else $error("pending count exceeds active pattern length");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || dout.ready))
        else $error("output register overwritten while held");

    a_total_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg == '1 && !cmd.total_clr) |=> (total_reg == '1))
        else $error("replacement count wrapped");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!cmd.match && !cmd.shift && !cmd.emit))
        else $error("accept overlaps buffer work");

endmodule

`default_nettype wire

// File: rtl/core/stream_find_replace.sv
// Streaming find-and-replace top level: controller plus datapath.
// A byte's first result is registered in the output register after its prefix check.
// A new input byte is accepted only in idle, after the last byte's results are emitted;
// each byte dropped from a failed partial match, each replacement or flushed byte
// and an end marker goes through the one-byte output register, which can stall on dout.ready.
// Reset clears state and counts and sets config registers to defaults; no clearing pass.
`default_nettype none

module stream_find_replace import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = SFR_MAX_PATTERN
)
(
    input  logic         clk,
    input  logic         rst_n,
    sfr_cfg_if.sink      cfg,
    sfr_stream_if.sink   din,
    sfr_stream_if.source dout
);

    sfr_cmd_t    cmd;
    sfr_status_t status;

    sfr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sfr_datapath #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .din    (din),
        .dout   (dout),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire

// File: bench/stream_find_replace_test.sv
// Self-checking bench for stream_find_replace: directed table, then random
// find/replace phases, checked against an in-bench edit predictor.
// Depends on sfr_pkg, sfr_stream_if, sfr_cfg_if and the RTL top level.
`default_nettype none

module stream_find_replace_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int MAX_STEP_RES  = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 150;
    localparam int LIMIT_CYCLES  = 300_000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 55;
    localparam int HOLD_PHASE    = 2;
    localparam int PAUSE_PHASE   = 4;

    // indexes past the register file; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = '1;

    typedef enum logic { ROW_REG, ROW_TEXT } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [63:0]          value;
        sfr_in_t              item;
        bit                   fixed;
        sfr_out_t             want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sfr_cfg_if                             cfg_if ();
    sfr_stream_if #(.payload_t(sfr_in_t))  din_if ();
    sfr_stream_if #(.payload_t(sfr_out_t)) dout_if ();

    stream_find_replace DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .din   (din_if),
        .dout  (dout_if)
    );

    // predictor state
    logic [63:0]  reg_search_pat;
    logic [3:0]   reg_search_len;
    logic [63:0]  reg_repl_pat;
    logic [3:0]   reg_repl_len;
    logic [63:0]  live_pat;
    int unsigned  live_len;
    logic [7:0]   held [SFR_MAX_PATTERN];
    int unsigned  held_n;
    logic [31:0]  hit_count;

    sfr_out_t  edited_q [$];
    stim_row_t plan [$];
    int        err_count = 0;

    bit       src_idle_on  = 1'b1;
    bit       sink_idle_on = 1'b1;
    bit       hold_req     = 1'b0;
    bit       fixed_armed;
    sfr_out_t fixed_res;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_len(logic [3:0] v, int unsigned lo);
        if (v < lo)
            return lo;
        if (v > SFR_MAX_PATTERN)
            return SFR_MAX_PATTERN;
        return v;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        case (idx)
            CFG_SEARCH_PATTERN:  reg_search_pat = value;
            CFG_SEARCH_LENGTH:   reg_search_len = value[3:0];
            CFG_REPLACE_PATTERN: reg_repl_pat   = value;
            CFG_REPLACE_LENGTH:  reg_repl_len   = value[3:0];
            default: ;
        endcase
    endfunction

    function automatic bit held_is_prefix();
        if (held_n > live_len)
            return 1'b0;
        for (int i = 0; i < held_n; i++)
            if (held[i] != live_pat[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // One input byte through the edit: returns the results it releases.
    function automatic int find_replace_step(input sfr_in_t item,
                                             output sfr_out_t res [MAX_STEP_RES]);
        int          n;
        int unsigned rlen;
        n = 0;
        foreach (res[i])
            res[i] = '0;
        // search registers only take effect between matches
        if (held_n == 0)
        begin
            live_pat = reg_search_pat;
            live_len = clamp_len(reg_search_len, 1);
        end
        held[held_n] = item.in_byte;
        held_n++;
        forever
        begin
            if (held_is_prefix())
            begin
                if (held_n == live_len)
                begin
                    if (hit_count != '1)
                        hit_count++;
                    rlen = clamp_len(reg_repl_len, 0);
                    for (int i = 0; i < rlen; i++)
                    begin
                        res[n] = '{reg_repl_pat[8*i +: 8], 1'b1, 1'b0, hit_count};
                        n++;
                    end
                    held_n = 0;
                end
                break;
            end
            res[n] = '{held[0], 1'b1, 1'b0, hit_count};
            n++;
            for (int i = 1; i < held_n; i++)
                held[i-1] = held[i];
            held_n--;
        end
        if (item.end_of_stream)
        begin
            for (int i = 0; i < held_n; i++)
            begin
                res[n] = '{held[i], 1'b1, 1'b0, hit_count};
                n++;
            end
            held_n = 0;
            if (n == 0)
            begin
                res[n] = '{8'h00, 1'b0, 1'b0, hit_count};
                n++;
            end
            res[n-1].last = 1'b1;
            hit_count = '0;
        end
        return n;
    endfunction

    function automatic void check_edit(sfr_out_t got);
        sfr_out_t want;
        if (edited_q.size() == 0)
        begin
            $error("unexpected transfer: out_byte %0h last %0b", got.out_byte, got.last);
            err_count++;
            return;
        end
        want = edited_q.pop_front();
        if (got.out_byte !== want.out_byte)
        begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            err_count++;
        end
        if (got.byte_valid !== want.byte_valid)
        begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
            err_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            err_count++;
        end
        if (got.replacements !== want.replacements)
        begin
            $error("replacements: expected %0d, got %0d", want.replacements, got.replacements);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin : observe
        sfr_out_t step_res [MAX_STEP_RES];
        int       n;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
                apply_reg_write(cfg_if.index, cfg_if.data);
            if (din_if.valid && din_if.ready)
            begin
                n = find_replace_step(din_if.data, step_res);
                if (fixed_armed)
                    edited_q.push_back(fixed_res);
                else
                    for (int i = 0; i < n; i++)
                        edited_q.push_back(step_res[i]);
            end
            if (dout_if.valid && dout_if.ready)
                check_edit(dout_if.data);
        end
    end

    // receiver: short random stalls, or one long hold-off on request
    initial
    begin
        dout_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                dout_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                dout_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            dout_if.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_byte(input sfr_in_t item, input bit fixed, input sfr_out_t want);
        cfg_if.valid <= 1'b0;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            din_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.data  <= item;
        fixed_armed  <= fixed;
        fixed_res    <= want;
        do @(posedge clk); while (!din_if.ready);
    endtask

    // valid is left high; the next send or drain lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    // a byte can be swallowed into a partial match, so let the block settle
    task automatic wait_drained();
        din_if.valid <= 1'b0;
        cfg_if.valid <= 1'b0;
        do @(posedge clk); while (edited_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        stim_row_t r;
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.value = value;
        r.item  = '0;
        r.fixed = 1'b0;
        r.want  = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_byte(logic [7:0] b, logic eos, bit fixed = 1'b0,
                                     sfr_out_t want = '0);
        stim_row_t r;
        r.kind  = ROW_TEXT;
        r.idx   = '0;
        r.value = '0;
        r.item  = '{in_byte: b, end_of_stream: eos};
        r.fixed = fixed;
        r.want  = want;
        plan.push_back(r);
    endfunction

    initial
    begin : stimulus
        logic [7:0]  sym [3];
        logic [7:0]  b;
        logic        eos;
        logic [3:0]  len_code;
        logic [3:0]  repl_code;
        logic [63:0] pat_word;
        int unsigned pat_len;
        int unsigned take;
        int unsigned pick;
        int unsigned sent;

        rst_n         = 1'b0;
        din_if.valid  = 1'b0;
        din_if.data   = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        fixed_armed   = 1'b0;
        fixed_res     = '0;

        reg_search_pat = '0;
        reg_search_len = 4'd1;
        reg_repl_pat   = '0;
        reg_repl_len   = 4'd0;
        live_pat       = '0;
        live_len       = 1;
        held_n         = 0;
        hit_count      = '0;

        // reset pattern is one zero byte deleted on match
        add_byte(8'h00, 1'b1, 1'b1, '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b1,
                                      replacements: 32'd1});
        add_byte(8'hFF, 1'b1, 1'b1, '{out_byte: 8'hFF, byte_valid: 1'b1, last: 1'b1,
                                      replacements: 32'd0});
        add_reg(CFG_SEARCH_PATTERN, 64'h0000_0000_0063_6261);
        add_reg(CFG_SEARCH_LENGTH, 64'd3);
        add_reg(CFG_REPLACE_PATTERN, 64'h0000_0000_0000_5958);
        add_reg(CFG_REPLACE_LENGTH, 64'd2);
        // failed partial match, then a hit, then a partial left in flight
        add_byte("x", 1'b0);
        add_byte("a", 1'b0);
        add_byte("b", 1'b0);
        add_byte("a", 1'b0);
        add_byte("b", 1'b0);
        add_byte("c", 1'b0);
        add_byte("d", 1'b0);
        add_byte("a", 1'b0);
        add_byte("b", 1'b0);
        // search change mid-match waits; replacement change applies at once
        add_reg(CFG_SEARCH_LENGTH, 64'd2);
        add_reg(CFG_REPLACE_LENGTH, 64'd1);
        add_byte("c", 1'b0);
        add_byte("a", 1'b0);
        add_byte("b", 1'b1);
        // longest pattern and replacement via clamped lengths
        add_reg(CFG_SEARCH_PATTERN, '1);
        add_reg(CFG_SEARCH_LENGTH, 64'hF);
        add_reg(CFG_REPLACE_PATTERN, 64'h0123_4567_89AB_CDEF);
        add_reg(CFG_REPLACE_LENGTH, 64'hF);
        add_reg(CFG_IDX_UNUSED_LO, 64'h0000_0000_0000_0001);
        add_reg(CFG_IDX_UNUSED_HI, 64'h0000_0000_0000_0002);
        for (int i = 0; i < SFR_MAX_PATTERN; i++)
            add_byte(8'hFF, i == SFR_MAX_PATTERN - 1);
        // zero search length acts as one
        add_reg(CFG_SEARCH_LENGTH, 64'd0);
        add_reg(CFG_REPLACE_LENGTH, 64'd0);
        add_byte(8'hFF, 1'b1, 1'b1, '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b1,
                                      replacements: 32'd1});
        add_byte(8'h00, 1'b1, 1'b1, '{out_byte: 8'h00, byte_valid: 1'b1, last: 1'b1,
                                      replacements: 32'd0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                wait_drained();
                write_reg(plan[i].idx, plan[i].value);
            end
            else
                send_byte(plan[i].item, plan[i].fixed, plan[i].want);
        end

        for (int k = 0; k < NUM_PHASES; k++)
        begin
            wait_drained();
            if (k == NUM_PHASES - 1)
            begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            // few symbols so that matches and self-overlapping prefixes are common
            foreach (sym[j])
                sym[j] = 8'($urandom);
            pat_len  = (k == 0) ? SFR_MAX_PATTERN : (k == 1) ? 1 : $urandom_range(1, 4);
            pat_word = {$urandom, $urandom};
            for (int j = 0; j < pat_len; j++)
                pat_word[8*j +: 8] = sym[$urandom_range(0, 2)];
            len_code = 4'(pat_len);
            if (pat_len == 1 && $urandom_range(0, 1) == 1)
                len_code = 4'd0;
            if (pat_len == SFR_MAX_PATTERN && $urandom_range(0, 1) == 1)
                len_code = 4'hF;
            repl_code = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                    : 4'($urandom_range(0, 8));
            write_reg(CFG_SEARCH_PATTERN, pat_word);
            write_reg(CFG_SEARCH_LENGTH, {$urandom, 28'($urandom), len_code});
            write_reg(CFG_REPLACE_PATTERN, {$urandom, $urandom});
            write_reg(CFG_REPLACE_LENGTH, {$urandom, 28'($urandom), repl_code});
            if (k % 3 == 1)
                write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED_HI, CFG_IDX_UNUSED_LO)),
                          {$urandom, $urandom});
            if (k == HOLD_PHASE)
                hold_req = 1'b1;

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                take = (pick < 40) ? pat_len : (pick < 60) ? $urandom_range(1, pat_len) : 1;
                for (int j = 0; j < take && sent < PHASE_ITEMS; j++)
                begin
                    if (pick < 60)
                        b = pat_word[8*j +: 8];
                    else if (pick < 85)
                        b = sym[$urandom_range(0, 2)];
                    else
                        b = 8'($urandom);
                    eos = ($urandom_range(0, 11) == 0) ||
                          (k == NUM_PHASES - 1 && sent == PHASE_ITEMS - 1);
                    send_byte('{in_byte: b, end_of_stream: eos}, 1'b0, '0);
                    sent++;
                    if (k == PAUSE_PHASE && sent == PHASE_ITEMS / 2)
                        wait_drained();
                end
            end
        end

        wait_drained();
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
